@@ rtl/chs_pkg.sv @@
// Shared types and constants of the chained hash set.
`default_nettype none
package chs_pkg;

  localparam int KEY_W    = 31;
  localparam int HASH_BITS  = 4;
  localparam int HASH_STEPS = 8;
  localparam int KSHIFT_W   = HASH_BITS * HASH_STEPS;
  localparam int STEP_W     = $clog2(HASH_STEPS);

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_SEARCH = 2'd1;
  localparam logic [1:0] CMD_DELETE = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_DISPATCH,
    S_INSERT,
    S_HEAD,
    S_NODE
  } state_t;

endpackage
`default_nettype wire

@@ rtl/chs_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module chs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ rtl/chained_hash_set.sv @@
// Top level of the chained hash set: sequencer, hash unit and node pool.
// A hash set of 31-bit keys with separate chaining over a pool of POOL_NODES
// nodes; the bucket is key modulo BUCKETS. After reset the block is busy
// while it clears the bucket heads. A word is taken when start is high and
// busy is low. The modulo unit then reduces four key bits per cycle, a
// dispatch state follows, and an insert finishes in the insert state (an
// insert into a full pool ends at dispatch with status FULL); a search or
// delete reads the bucket head and then walks the chain node by node, each
// step bound by the node memory read. The result shows on status and bucket
// with done high for exactly one cycle, right after the last working cycle.
// The receiver cannot stall; done is a one-cycle strobe.
`default_nettype none
module chained_hash_set
  import chs_pkg::*;
#(
  parameter int BUCKETS    = 16,
  parameter int POOL_NODES = 64
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire logic [1:0]       command,
  input  wire logic [KEY_W-1:0] key,
  output logic                  done,
  output logic [1:0]            status,
  output logic [3:0]            bucket
);

  localparam int BW = $clog2(BUCKETS);
  localparam int NW = $clog2(POOL_NODES);
  localparam int LW = NW + 1;
  localparam int CW = $clog2(POOL_NODES + 1);
  localparam logic [BW:0]   BKT       = (BW+1)'(BUCKETS);
  localparam logic [BW-1:0] BKT_LAST  = BW'(BUCKETS - 1);
  localparam logic [CW-1:0] POOL_FULL = CW'(POOL_NODES);

  state_t            state, state_next;
  logic [BW-1:0]     clr_cnt, clr_cnt_next;
  logic [1:0]        cmd, cmd_next;
  logic [KEY_W-1:0]  key_q, key_q_next;
  logic [KSHIFT_W-1:0] kshift, kshift_next;
  logic [STEP_W-1:0] step, step_next;
  logic [BW-1:0]     rem, rem_next, rem_step;
  logic [CW-1:0]     free_count, free_count_next;
  logic [CW-1:0]     lowmark, lowmark_next;
  logic [NW-1:0]     cur, cur_next;
  logic [NW-1:0]     prev, prev_next;
  logic              from_head, from_head_next;
  logic              done_next;
  logic [1:0]        status_next;

  logic              head_we;
  logic [BW-1:0]     head_waddr, head_raddr;
  logic [LW-1:0]     head_wdata, head_rd;
  logic              key_we, link_we;
  logic [NW-1:0]     key_waddr, link_waddr, node_raddr;
  logic [KEY_W-1:0]  key_wdata, key_rd;
  logic [LW-1:0]     link_wdata, link_rd;
  logic              free_we;
  logic [NW-1:0]     free_waddr, free_raddr, free_wdata, free_rd;

  logic [CW-1:0]     pos_full;
  logic [NW-1:0]     pos;
  logic              fresh;
  logic [NW-1:0]     new_node;
  logic [LW-1:0]     lk;

  chs_ram #(.WIDTH(LW), .DEPTH(BUCKETS)) u_heads (
    .clk(clk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
    .raddr(head_raddr), .rdata(head_rd)
  );

  chs_ram #(.WIDTH(KEY_W), .DEPTH(POOL_NODES)) u_keys (
    .clk(clk), .we(key_we), .waddr(key_waddr), .wdata(key_wdata),
    .raddr(node_raddr), .rdata(key_rd)
  );

  chs_ram #(.WIDTH(LW), .DEPTH(POOL_NODES)) u_links (
    .clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
    .raddr(node_raddr), .rdata(link_rd)
  );

  chs_ram #(.WIDTH(NW), .DEPTH(POOL_NODES)) u_free (
    .clk(clk), .we(free_we), .waddr(free_waddr), .wdata(free_wdata),
    .raddr(free_raddr), .rdata(free_rd)
  );

  // reduce the next HASH_BITS key bits, most significant first
  always_comb begin
    logic [BW:0]   t;
    logic [BW-1:0] r;
    r = rem;
    for (int i = 0; i < HASH_BITS; i++) begin
      t = {r, kshift[KSHIFT_W-1-i]};
      if (t >= BKT) begin
        t = t - BKT;
      end
      r = t[BW-1:0];
    end
    rem_step = r;
  end

  assign pos_full = free_count - CW'(1);
  assign pos      = pos_full[NW-1:0];
  assign fresh    = (free_count <= lowmark);
  assign new_node = fresh ? pos : free_rd;
  assign lk       = (state == S_NODE) ? link_rd : head_rd;

  assign busy   = (state != S_IDLE);
  assign bucket = 4'(rem);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_cnt    <= '0;
      free_count <= POOL_FULL;
      lowmark    <= POOL_FULL;
      done       <= 1'b0;
    end else begin
      state      <= state_next;
      clr_cnt    <= clr_cnt_next;
      free_count <= free_count_next;
      lowmark    <= lowmark_next;
      done       <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    cmd       <= cmd_next;
    key_q     <= key_q_next;
    kshift    <= kshift_next;
    step      <= step_next;
    rem       <= rem_next;
    cur       <= cur_next;
    prev      <= prev_next;
    from_head <= from_head_next;
    status    <= status_next;
  end

  always_comb begin
    state_next      = state;
    clr_cnt_next    = clr_cnt;
    cmd_next        = cmd;
    key_q_next      = key_q;
    kshift_next     = kshift;
    step_next       = step;
    rem_next        = rem;
    free_count_next = free_count;
    lowmark_next    = lowmark;
    cur_next        = cur;
    prev_next       = prev;
    from_head_next  = from_head;
    done_next       = 1'b0;
    status_next     = status;

    head_we    = 1'b0;
    head_waddr = rem;
    head_wdata = '0;
    head_raddr = rem;
    key_we     = 1'b0;
    key_waddr  = new_node;
    key_wdata  = key_q;
    link_we    = 1'b0;
    link_waddr = new_node;
    link_wdata = head_rd;
    node_raddr = lk[NW-1:0];
    free_we    = 1'b0;
    free_waddr = free_count[NW-1:0];
    free_wdata = cur;
    free_raddr = pos;

    case (state)
      S_CLEAR: begin
        head_we    = 1'b1;
        head_waddr = clr_cnt;
        if (clr_cnt == BKT_LAST) begin
          state_next = S_IDLE;
        end else begin
          clr_cnt_next = clr_cnt + BW'(1);
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd_next    = command;
          key_q_next  = key;
          kshift_next = KSHIFT_W'(key);
          rem_next    = '0;
          step_next   = '0;
          state_next  = S_HASH;
        end
      end
      S_HASH: begin
        rem_next    = rem_step;
        kshift_next = kshift << HASH_BITS;
        step_next   = step + STEP_W'(1);
        if (step == STEP_W'(HASH_STEPS - 1)) begin
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        from_head_next = 1'b1;
        case (cmd)
          CMD_INSERT: begin
            if (free_count == '0) begin
              status_next = ST_FULL;
              done_next   = 1'b1;
              state_next  = S_IDLE;
            end else begin
              state_next = S_INSERT;
            end
          end
          CMD_SEARCH, CMD_DELETE: begin
            state_next = S_HEAD;
          end
          default: begin
            status_next = ST_NOT_FOUND;
            done_next   = 1'b1;
            state_next  = S_IDLE;
          end
        endcase
      end
      S_INSERT: begin
        key_we          = 1'b1;
        link_we         = 1'b1;
        head_we         = 1'b1;
        head_wdata      = {1'b1, new_node};
        free_count_next = pos_full;
        if (fresh) begin
          lowmark_next = pos_full;
        end
        status_next = ST_OK;
        done_next   = 1'b1;
        state_next  = S_IDLE;
      end
      S_HEAD, S_NODE: begin
        if (state == S_NODE && key_rd == key_q) begin
          if (cmd == CMD_DELETE) begin
            if (from_head) begin
              head_we    = 1'b1;
              head_wdata = link_rd;
            end else begin
              link_we    = 1'b1;
              link_waddr = prev;
              link_wdata = link_rd;
            end
            if (free_count < POOL_FULL) begin
              free_we         = 1'b1;
              free_count_next = free_count + CW'(1);
            end
          end
          status_next = ST_OK;
          done_next   = 1'b1;
          state_next  = S_IDLE;
        end else begin
          if (state == S_NODE) begin
            prev_next      = cur;
            from_head_next = 1'b0;
          end
          if (!lk[NW]) begin
            status_next = ST_NOT_FOUND;
            done_next   = 1'b1;
            state_next  = S_IDLE;
          end else begin
            cur_next   = lk[NW-1:0];
            state_next = S_NODE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted word did not start work");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    free_count <= POOL_FULL)
    else $error("free count above pool size");

  a_lowmark: assert property (@(posedge clk) disable iff (rst)
    lowmark <= free_count)
    else $error("free stack low mark above free count");

endmodule
`default_nettype wire
